// ===== sv/rbe_pkg.sv =====
// Shared types and constants for the byte-wise rANS encoder.
// No dependencies; the divider, output stage and top level import this package.
package rbe_pkg;

  // Coder configuration
  localparam int unsigned PROB_BITS         = 12;
  localparam int unsigned STATE_LOWER_BOUND = 8388608;
  localparam int unsigned ALPHABET          = 256;

  // Field and datapath widths
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SYMBOL_W  = 8;
  localparam int unsigned COUNT_W   = 12;
  localparam int unsigned START_W   = 12;
  localparam int unsigned ENTRY_W   = COUNT_W + START_W;
  localparam int unsigned TBL_ADDR_W = $clog2(ALPHABET);

  // Renormalisation threshold per unit of count
  localparam int unsigned XMAX_BASE = (STATE_LOWER_BOUND >> PROB_BITS) << BYTE_W;
  localparam int unsigned XMAX_W    = $clog2(XMAX_BASE + 1) + COUNT_W;
  localparam int unsigned CMP_W     = (XMAX_W > STATE_W) ? XMAX_W : STATE_W;

  // Byte counts
  localparam int unsigned MAX_RENORM   = 5;
  localparam int unsigned RENORM_CNT_W = 3;
  localparam int unsigned STATE_BYTES  = STATE_W / BYTE_W;
  localparam int unsigned LEN_W        = $clog2(STATE_BYTES + 1);

  // Divider
  localparam int unsigned DIV_CNT_W = $clog2(STATE_W);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } rbe_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RENORM,
    ST_DIV,
    ST_ERROR,
    ST_FLUSH_SCAN,
    ST_FLUSH_LEN,
    ST_FLUSH_BYTE
  } rbe_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_flush_byte;
    logic              error;
    logic              last;
  } rbe_result_t;

endpackage

// ===== sv/rbe_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module rbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rbe_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rbe_pkg for the state and count widths.
module rbe_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rbe_pkg::STATE_W-1:0]  dividend_i,
  input  logic [rbe_pkg::COUNT_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [rbe_pkg::STATE_W-1:0]  quotient_o,
  output logic [rbe_pkg::COUNT_W-1:0]  remainder_o
);
  import rbe_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [STATE_W-1:0]   quo_q, quo_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]   dvs_q, dvs_d;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     diff;
  logic                 fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[STATE_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[STATE_W-2:0], fits};
      rem_d = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(STATE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== sv/rbe_out_stage.sv =====
// Output holding register for the result stream.
// Depends on rbe_pkg for the result type.
module rbe_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rbe_pkg::rbe_result_t res_i,
  output logic                 ready_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,  // out_byte
  output logic [1:0]           m_axis_tuser_o,  // is_flush_byte, error
  output logic                 m_axis_tlast_o   // last
);
  import rbe_pkg::*;

  logic        valid_q, valid_d;
  rbe_result_t res_q;

  // Accept a new result when empty or when the held one leaves this cycle
  assign ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && ready_o) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.out_byte;
  assign m_axis_tuser_o  = {res_q.error, res_q.is_flush_byte};
  assign m_axis_tlast_o  = res_q.last;

endmodule

// ===== sv/rans_byte_encoder_unit.sv =====
// Top level of the byte-wise rANS encoder: control sequencer and coder state.
// Depends on rbe_pkg, rbe_ram, rbe_divider and rbe_out_stage.
//
// Byte-wise rANS encoder with a 32-bit coder state. The input stream carries the
// operation in tuser (0 load, 1 encode, 2 flush, 3 ignored) and symbol, count and
// cumulative start in tdata. A load writes one table entry. Symbols must be
// encoded in reverse of source order. An encode reads the table through the
// registered RAM port, emits one renormalisation byte a cycle while the state is
// at or above the scaled bound and the output accepts, then runs a bit-serial
// divider that delivers one quotient bit a cycle; with the default constants an
// encode emits at most two bytes. A symbol with zero count gives a single result
// with error set and leaves the state unchanged. A flush scans the state one byte
// a cycle for its length, then emits the length byte and the significant state
// bytes, most significant first, and returns the state to the lower bound.
// Renormalisation bytes leave in the order generated; software reverses them.
// Input is taken only between items; a result register on the output lets the
// next item in while the last result waits. Encoding a symbol that was never
// loaded yields undefined bytes.
module rans_byte_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // symbol[7:0], frequency[19:8], cumulative_start[31:20]
  input  logic [1:0]  s_axis_tuser_i,   // operation[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte[7:0]
  output logic [1:0]  m_axis_tuser_o,   // is_flush_byte[0], error[1]
  output logic        m_axis_tlast_o    // last
);
  import rbe_pkg::*;

  rbe_state_e state_q, state_d;

  logic [STATE_W-1:0]      x_q, x_d;
  logic [COUNT_W-1:0]      count_q, count_d;
  logic [START_W-1:0]      start_q, start_d;
  logic [XMAX_W-1:0]       xmax_q, xmax_d;
  logic [RENORM_CNT_W-1:0] n_q, n_d;
  logic [LEN_W-1:0]        len_q, len_d;

  // Input decode
  logic                in_xfer;
  rbe_op_e             in_op;
  logic [SYMBOL_W-1:0] in_symbol;
  logic [COUNT_W-1:0]  in_freq;
  logic [START_W-1:0]  in_start;
  logic                in_sym_ok;

  // Table
  logic                ram_we;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [COUNT_W-1:0]  rd_count;
  logic [START_W-1:0]  rd_start;
  logic                sym_ok_q;

  // Divider
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [STATE_W-1:0]  div_quo;
  logic [COUNT_W-1:0]  div_rem;
  logic [STATE_W-1:0]  x_update;

  // Result path
  logic        push;
  logic        out_ready;
  rbe_result_t res;

  // Renormalisation compares, this byte and the one after
  logic renorm_now;
  logic renorm_next;

  assign in_symbol = s_axis_tdata_i[7:0];
  assign in_freq   = s_axis_tdata_i[19:8];
  assign in_start  = s_axis_tdata_i[31:20];
  assign in_op     = rbe_op_e'(s_axis_tuser_i);
  assign in_sym_ok = {1'b0, in_symbol} < (SYMBOL_W + 1)'(ALPHABET);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Write on load, read on encode; symbols beyond the alphabet touch nothing
  assign ram_we = in_xfer && (in_op == OP_LOAD) && in_sym_ok;
  assign ram_re = in_xfer && (in_op == OP_ENCODE) && in_sym_ok;

  rbe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ALPHABET)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (in_symbol[TBL_ADDR_W-1:0]),
    .wdata_i ({in_start, in_freq}),
    .rdata_o (ram_rdata)
  );

  assign rd_count = ram_rdata[COUNT_W-1:0];
  assign rd_start = ram_rdata[ENTRY_W-1:COUNT_W];

  rbe_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (x_q),
    .divisor_i   (count_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // New state: (x / count) << PROB_BITS, plus remainder and start, modulo 2^32
  assign x_update = {div_quo[STATE_W-PROB_BITS-1:0], {PROB_BITS{1'b0}}}
                  + STATE_W'(div_rem) + STATE_W'(start_q);

  assign renorm_now  = (CMP_W'(x_q) >= CMP_W'(xmax_q)) && (n_q < RENORM_CNT_W'(MAX_RENORM));
  assign renorm_next = (CMP_W'(x_q >> BYTE_W) >= CMP_W'(xmax_q))
                    && (n_q < RENORM_CNT_W'(MAX_RENORM - 1));

  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    count_d   = count_q;
    start_d   = start_q;
    xmax_d    = xmax_q;
    n_d       = n_q;
    len_d     = len_q;
    div_start = 1'b0;
    push      = 1'b0;
    res       = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_ENCODE: state_d = ST_READ;
            OP_FLUSH: begin
              len_d   = LEN_W'(STATE_BYTES);
              state_d = ST_FLUSH_SCAN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_READ: begin
        // Latch the entry and scale the bound by the count
        count_d = rd_count;
        start_d = rd_start;
        xmax_d  = XMAX_W'(XMAX_BASE) * XMAX_W'(rd_count);
        n_d     = '0;
        if (!sym_ok_q || (rd_count == '0)) begin
          state_d = ST_ERROR;
        end else begin
          state_d = ST_RENORM;
        end
      end

      ST_RENORM: begin
        if (renorm_now) begin
          // Emit the low byte and drop it from the state
          res.out_byte = x_q[BYTE_W-1:0];
          res.last     = !renorm_next;
          push         = out_ready;
          if (out_ready) begin
            x_d = x_q >> BYTE_W;
            n_d = n_q + 1'b1;
          end
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          x_d     = x_update;
          state_d = ST_IDLE;
        end
      end

      ST_ERROR: begin
        res.error = 1'b1;
        res.last  = 1'b1;
        push      = out_ready;
        if (out_ready) begin
          state_d = ST_IDLE;
        end
      end

      ST_FLUSH_SCAN: begin
        // Skip leading zero bytes, one per cycle
        if ((len_q != '0) && (x_q[STATE_W-1 -: BYTE_W] == '0)) begin
          x_d   = x_q << BYTE_W;
          len_d = len_q - 1'b1;
        end else begin
          state_d = ST_FLUSH_LEN;
        end
      end

      ST_FLUSH_LEN: begin
        res.out_byte      = BYTE_W'(len_q);
        res.is_flush_byte = 1'b1;
        res.last          = (len_q == '0);
        push              = out_ready;
        if (out_ready) begin
          if (len_q == '0) begin
            x_d     = STATE_W'(STATE_LOWER_BOUND);
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FLUSH_BYTE;
          end
        end
      end

      ST_FLUSH_BYTE: begin
        res.out_byte      = x_q[STATE_W-1 -: BYTE_W];
        res.is_flush_byte = 1'b1;
        res.last          = (len_q == LEN_W'(1));
        push              = out_ready;
        if (out_ready) begin
          x_d   = x_q << BYTE_W;
          len_d = len_q - 1'b1;
          if (len_q == LEN_W'(1)) begin
            x_d     = STATE_W'(STATE_LOWER_BOUND);
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= STATE_W'(STATE_LOWER_BOUND);
      n_q     <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      n_q     <= n_d;
      len_q   <= len_d;
    end
  end

  // Entry data and symbol check; no reset needed
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    start_q <= start_d;
    xmax_q  <= xmax_d;
    if (in_xfer) begin
      sym_ok_q <= in_sym_ok;
    end
  end

  rbe_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .res_i           (res),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // The divider reports completion only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division step");

  // Input is taken only with the divider at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("input ready while division in progress");

  // An error result is a lone zero byte closing its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      ((m_axis_tdata_o == '0) && m_axis_tlast_o && !m_axis_tuser_o[0]))
    else $error("malformed error result");

  // The final flush byte returns the state to the lower bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH_BYTE) && push && (len_q == LEN_W'(1))) |=>
      (x_q == STATE_W'(STATE_LOWER_BOUND)))
    else $error("state not restored after flush");

endmodule
